FILE: design/tcprst_pkg.sv
package tcprst_pkg;

  localparam int unsigned DefaultPacketsPerFlow = 5;
  localparam int unsigned MaxPacketsPerFlow = 8;
  localparam int unsigned FifoDepth = 2;

  localparam logic [2:0] LAST_WORD = 3'd6;
  localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
  localparam logic [3:0] END_WORD_BYTES = 4'd6;

  localparam logic [15:0] ETH_TYPE_IP = 16'h0800;
  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [15:0] IP_TOTAL_LEN = 16'd40;
  localparam logic [15:0] IP_TTL_PROTO = 16'hFF06;
  localparam logic [15:0] IP_PROTO_TCP = 16'h0006;
  localparam logic [15:0] TCP_LEN = 16'd20;
  localparam logic [7:0] TCP_DATA_OFFSET = 8'h50;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [15:0] WIN_FULL = 16'hFFFF;
  localparam logic [31:0] SEG_SIZE = 32'd1460;
  localparam logic [31:0] SEG_SIZE_X3 = 32'd4380;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] client_ip;
    logic [31:0] server_ip;
    logic [15:0] client_port;
    logic [15:0] server_port;
    logic [31:0] acked;
    logic [31:0] expected;
  } flow_t;

  typedef struct packed {
    flow_t       flow;
    logic [15:0] ip_csum;
    logic [18:0] tcp_base;
  } job_t;

  // One's-complement fold of a sum of 16-bit words, then inverted.
  function automatic logic [15:0] csum_fold(input logic [19:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    b = {1'b0, a[15:0]} + {16'b0, a[16]};
    return ~b[15:0];
  endfunction

endpackage

FILE: design/tcprst_front.sv
module tcprst_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tcprst_pkg::flow_t   flow_i,
  output logic                job_push_o,
  output tcprst_pkg::job_t    job_o,
  input  logic                job_full_i
);

  logic              stage_valid_q, stage_valid_d;
  tcprst_pkg::flow_t stage_q;
  logic              accept;
  logic [19:0]       ip_sum;
  logic [19:0]       tcp_sum;

  assign full = stage_valid_q && job_full_i;
  assign accept = push && !full;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (!job_full_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= flow_i;
    end
  end

  // IP header sum: fixed fields plus the swapped addresses.
  assign ip_sum = {4'b0, tcprst_pkg::IP_VER_IHL_TOS} + {4'b0, tcprst_pkg::IP_TOTAL_LEN}
                + {4'b0, tcprst_pkg::IP_TTL_PROTO}
                + {4'b0, stage_q.server_ip[31:16]} + {4'b0, stage_q.server_ip[15:0]}
                + {4'b0, stage_q.client_ip[31:16]} + {4'b0, stage_q.client_ip[15:0]};

  // The part of the TCP checksum that is the same for every packet of a flow.
  assign tcp_sum = {4'b0, stage_q.server_ip[31:16]} + {4'b0, stage_q.server_ip[15:0]}
                 + {4'b0, stage_q.client_ip[31:16]} + {4'b0, stage_q.client_ip[15:0]}
                 + {4'b0, tcprst_pkg::IP_PROTO_TCP} + {4'b0, tcprst_pkg::TCP_LEN}
                 + {4'b0, stage_q.server_port} + {4'b0, stage_q.client_port};

  assign job_push_o = stage_valid_q && !job_full_i;
  assign job_o.flow = stage_q;
  assign job_o.ip_csum = tcprst_pkg::csum_fold(ip_sum);
  assign job_o.tcp_base = tcp_sum[18:0];

endmodule

FILE: design/tcprst_fifo.sv
module tcprst_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  tcprst_pkg::job_t wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output tcprst_pkg::job_t rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(tcprst_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(tcprst_pkg::FifoDepth + 1);
  localparam logic [CntW-1:0] DepthCount = CntW'(tcprst_pkg::FifoDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(tcprst_pkg::FifoDepth - 1);

  tcprst_pkg::job_t mem_q [tcprst_pkg::FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_wr, do_rd;

  assign full_o = (count_q == DepthCount);
  assign empty_o = (count_q == '0);
  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: design/tcprst_back.sv
module tcprst_back #(
  parameter int unsigned PACKETS_PER_FLOW = tcprst_pkg::DefaultPacketsPerFlow
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcprst_pkg::job_t job_i,
  input  logic             job_empty_i,
  output logic             job_pop_o,
  output logic             empty,
  input  logic             pop,
  output logic [63:0]      frame_word_o,
  output logic [3:0]       valid_bytes_o,
  output logic [2:0]       packet_number_o,
  output logic             packet_end_o,
  output logic             last_o
);

  localparam int unsigned PktCount =
    (PACKETS_PER_FLOW < 1) ? 1 :
    (PACKETS_PER_FLOW > tcprst_pkg::MaxPacketsPerFlow) ? tcprst_pkg::MaxPacketsPerFlow :
    PACKETS_PER_FLOW;
  localparam logic [2:0] LastPkt = 3'(PktCount - 1);

  logic        out_valid_q;
  logic [63:0] word_q;
  logic [3:0]  bytes_q;
  logic [2:0]  pkt_out_q;
  logic        end_q, last_q;

  logic [2:0]  word_idx_q, pkt_idx_q;
  logic [31:0] seq_q;
  logic [19:0] sum_q;
  logic [15:0] csum_q;

  logic        load;
  logic        word_end, flow_end;
  logic [31:0] seq_off, ack_num;
  logic [7:0]  flags;
  logic [15:0] window;
  logic [19:0] sum_d;
  logic [63:0] word_d;
  tcprst_pkg::flow_t fl;

  assign fl = job_i.flow;
  assign load = !job_empty_i && (!out_valid_q || pop);
  assign word_end = (word_idx_q == tcprst_pkg::LAST_WORD);
  assign flow_end = word_end && (pkt_idx_q == LastPkt);
  assign job_pop_o = load && flow_end;

  // Per-packet variation of sequence, acknowledgment, flags and window.
  always_comb begin
    seq_off = '0;
    ack_num = fl.expected;
    flags = tcprst_pkg::FLAG_RST | tcprst_pkg::FLAG_ACK;
    window = tcprst_pkg::WIN_FULL;
    unique case (pkt_idx_q)
      3'd0: seq_off = tcprst_pkg::SEG_SIZE_X3;
      3'd2: seq_off = tcprst_pkg::SEG_SIZE;
      3'd3: flags = tcprst_pkg::FLAG_ACK;
      3'd4: begin
        ack_num = '0;
        flags = tcprst_pkg::FLAG_RST;
        window = '0;
      end
      default: ;
    endcase
  end

  assign sum_d = {1'b0, job_i.tcp_base}
               + {4'b0, seq_q[31:16]} + {4'b0, seq_q[15:0]}
               + {4'b0, ack_num[31:16]} + {4'b0, ack_num[15:0]}
               + {4'b0, tcprst_pkg::TCP_DATA_OFFSET, flags} + {4'b0, window};

  // The sequence number is ready before word 4 and the checksum before word 6.
  always_comb begin
    unique case (word_idx_q)
      3'd0: word_d = {fl.dest_mac, fl.source_mac[47:32]};
      3'd1: word_d = {fl.source_mac[31:0], tcprst_pkg::ETH_TYPE_IP,
                      tcprst_pkg::IP_VER_IHL_TOS};
      3'd2: word_d = {tcprst_pkg::IP_TOTAL_LEN, 32'h0, tcprst_pkg::IP_TTL_PROTO};
      3'd3: word_d = {job_i.ip_csum, fl.server_ip, fl.client_ip[31:16]};
      3'd4: word_d = {fl.client_ip[15:0], fl.server_port, fl.client_port, seq_q[31:16]};
      3'd5: word_d = {seq_q[15:0], ack_num, tcprst_pkg::TCP_DATA_OFFSET, flags};
      3'd6: word_d = {window, csum_q, 32'h0};
      default: word_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      word_idx_q <= '0;
      pkt_idx_q <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (word_end) begin
          word_idx_q <= '0;
          pkt_idx_q <= flow_end ? '0 : pkt_idx_q + 3'd1;
        end else begin
          word_idx_q <= word_idx_q + 3'd1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      bytes_q <= word_end ? tcprst_pkg::END_WORD_BYTES : tcprst_pkg::FULL_WORD_BYTES;
      pkt_out_q <= pkt_idx_q;
      end_q <= word_end;
      last_q <= flow_end;
      if (word_idx_q == 3'd0) begin
        seq_q <= fl.acked + seq_off;
      end
      if (word_idx_q == 3'd1) begin
        sum_q <= sum_d;
      end
      if (word_idx_q == 3'd2) begin
        csum_q <= tcprst_pkg::csum_fold(sum_q);
      end
    end
  end

  assign empty = !out_valid_q;
  assign frame_word_o = word_q;
  assign valid_bytes_o = bytes_q;
  assign packet_number_o = pkt_out_q;
  assign packet_end_o = end_q;
  assign last_o = last_q;

endmodule

FILE: design/tcp_reset_frame_builder.sv
// The first word of a flow record passes the input stage, the queue and the output register in turn.
// Throughput: one frame word per cycle while the receiver keeps pop high, set by the word sequencer
// of the back end; the front end takes the next record meanwhile.
// Reset: asynchronous, active low; it empties the input stage, the queue and the output register.
module tcp_reset_frame_builder #(
  parameter int unsigned PACKETS_PER_FLOW = tcprst_pkg::DefaultPacketsPerFlow
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [47:0] frame_dest_mac_i,
  input  logic [47:0] frame_source_mac_i,
  input  logic [31:0] client_ip_i,
  input  logic [31:0] server_ip_i,
  input  logic [15:0] client_port_i,
  input  logic [15:0] server_port_i,
  input  logic [31:0] acked_sequence_i,
  input  logic [31:0] expected_sequence_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] frame_word_o,
  output logic [3:0]  valid_bytes_o,
  output logic [2:0]  packet_number_o,
  output logic        packet_end_o,
  output logic        last_o
);

  tcprst_pkg::flow_t flow;
  tcprst_pkg::job_t  job_wr, job_rd;
  logic              job_push, job_full, job_pop, job_empty;

  assign flow.dest_mac = frame_dest_mac_i;
  assign flow.source_mac = frame_source_mac_i;
  assign flow.client_ip = client_ip_i;
  assign flow.server_ip = server_ip_i;
  assign flow.client_port = client_port_i;
  assign flow.server_port = server_port_i;
  assign flow.acked = acked_sequence_i;
  assign flow.expected = expected_sequence_i;

  tcprst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .flow_i     (flow),
    .job_push_o (job_push),
    .job_o      (job_wr),
    .job_full_i (job_full)
  );

  tcprst_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_push),
    .wr_data_i (job_wr),
    .full_o    (job_full),
    .rd_en_i   (job_pop),
    .rd_data_o (job_rd),
    .empty_o   (job_empty)
  );

  tcprst_back #(
    .PACKETS_PER_FLOW (PACKETS_PER_FLOW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job_rd),
    .job_empty_i     (job_empty),
    .job_pop_o       (job_pop),
    .empty           (empty),
    .pop             (pop),
    .frame_word_o    (frame_word_o),
    .valid_bytes_o   (valid_bytes_o),
    .packet_number_o (packet_number_o),
    .packet_end_o    (packet_end_o),
    .last_o          (last_o)
  );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PacketsPerFlow = tcprst_pkg::DefaultPacketsPerFlow;

  // Header constants, kept apart from the package so the check stays independent.
  localparam logic [15:0] EthTypeIpv4 = 16'h0800;
  localparam logic [15:0] IpVerIhlTos = 16'h4500;
  localparam logic [15:0] IpTotalLen = 16'd40;
  localparam logic [15:0] IpTtlProto = 16'hFF06;
  localparam logic [15:0] ProtoTcp = 16'd6;
  localparam logic [15:0] TcpHdrLen = 16'd20;
  localparam logic [7:0] TcpDataOffset = 8'h50;
  localparam logic [7:0] TcpFlagRst = 8'h04;
  localparam logic [7:0] TcpFlagAck = 8'h10;
  localparam logic [15:0] WindowOpen = 16'hFFFF;
  localparam logic [31:0] SegmentSize = 32'd1460;
  localparam int WordsPerFrame = 7;
  localparam int DirectedCount = 11;
  localparam int RandomCount = 440;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic [2:0]  pkt;
    logic        pkt_end;
    logic        last_word;
  } frame_word_t;

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    s = {16'h0, s[31:16]} + {16'h0, s[15:0]};
    s = s + (s >> 16);
    return ~s[15:0];
  endfunction

  class frame_scoreboard;
    frame_word_t expected_words[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Builds every frame word that one flow record causes.
    function void add_flow(input tcprst_pkg::flow_t fl);
      logic [447:0] frame;
      logic [31:0] ip_sum;
      logic [31:0] tcp_sum;
      logic [31:0] seq;
      logic [31:0] ackn;
      logic [15:0] ip_csum;
      logic [15:0] tcp_csum;
      logic [15:0] win;
      logic [7:0] flags;
      int npkt;
      frame_word_t w;
      npkt = PacketsPerFlow;
      if (npkt < 1) npkt = 1;
      if (npkt > 8) npkt = 8;
      ip_sum = IpVerIhlTos + IpTotalLen + IpTtlProto + fl.server_ip[31:16] +
               fl.server_ip[15:0] + fl.client_ip[31:16] + fl.client_ip[15:0];
      ip_csum = ones_fold(ip_sum);
      for (int k = 0; k < npkt; k++) begin
        seq = fl.acked;
        ackn = fl.expected;
        flags = TcpFlagRst | TcpFlagAck;
        win = WindowOpen;
        if (k == 0) begin
          seq = fl.acked + 3 * SegmentSize;
        end else if (k == 2) begin
          seq = fl.acked + SegmentSize;
        end else if (k == 3) begin
          flags = TcpFlagAck;
        end else if (k == 4) begin
          ackn = '0;
          flags = TcpFlagRst;
          win = '0;
        end
        tcp_sum = fl.server_ip[31:16] + fl.server_ip[15:0] + fl.client_ip[31:16] +
                  fl.client_ip[15:0] + ProtoTcp + TcpHdrLen + fl.server_port +
                  fl.client_port + seq[31:16] + seq[15:0] + ackn[31:16] + ackn[15:0] +
                  {TcpDataOffset, flags} + win;
        tcp_csum = ones_fold(tcp_sum);
        frame = {fl.dest_mac, fl.source_mac, EthTypeIpv4, IpVerIhlTos, IpTotalLen,
                 32'h0, IpTtlProto, ip_csum, fl.server_ip, fl.client_ip,
                 fl.server_port, fl.client_port, seq, ackn, TcpDataOffset, flags,
                 win, tcp_csum, 16'h0, 16'h0};
        for (int i = 0; i < WordsPerFrame; i++) begin
          w.data = frame[447 - 64 * i -: 64];
          w.pkt_end = (i == WordsPerFrame - 1);
          w.nbytes = w.pkt_end ? 4'd6 : 4'd8;
          w.pkt = k[2:0];
          w.last_word = w.pkt_end && (k == npkt - 1);
          expected_words.push_back(w);
        end
      end
    endfunction

    function void check_word(input frame_word_t got);
      frame_word_t exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected frame word %h", got.data);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.data !== exp_w.data || got.nbytes !== exp_w.nbytes ||
          got.pkt !== exp_w.pkt || got.pkt_end !== exp_w.pkt_end ||
          got.last_word !== exp_w.last_word) begin
        errors++;
        if (errors <= 10) begin
          $display("frame word mismatch: expected %h bytes %0d pkt %0d end %b last %b",
                   exp_w.data, exp_w.nbytes, exp_w.pkt, exp_w.pkt_end, exp_w.last_word);
          $display("                     got      %h bytes %0d pkt %0d end %b last %b",
                   got.data, got.nbytes, got.pkt, got.pkt_end, got.last_word);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic              empty;
  logic              pop = 1'b0;
  tcprst_pkg::flow_t drive_flow = '0;
  logic [63:0]       frame_word_o;
  logic [3:0]        valid_bytes_o;
  logic [2:0]        packet_number_o;
  logic              packet_end_o;
  logic              last_o;

  frame_scoreboard sb;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  tcp_reset_frame_builder #(
    .PACKETS_PER_FLOW(PacketsPerFlow)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .frame_dest_mac_i    (drive_flow.dest_mac),
    .frame_source_mac_i  (drive_flow.source_mac),
    .client_ip_i         (drive_flow.client_ip),
    .server_ip_i         (drive_flow.server_ip),
    .client_port_i       (drive_flow.client_port),
    .server_port_i       (drive_flow.server_port),
    .acked_sequence_i    (drive_flow.acked),
    .expected_sequence_i (drive_flow.expected),
    .empty               (empty),
    .pop                 (pop),
    .frame_word_o        (frame_word_o),
    .valid_bytes_o       (valid_bytes_o),
    .packet_number_o     (packet_number_o),
    .packet_end_o        (packet_end_o),
    .last_o              (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] rand_port();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] rand_word32();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [31:0] hi;
    hi = $urandom();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {hi[15:0], $urandom()};
    endcase
  endfunction

  function automatic tcprst_pkg::flow_t rand_flow();
    tcprst_pkg::flow_t fl;
    fl.dest_mac = rand_mac();
    fl.source_mac = rand_mac();
    fl.client_ip = rand_word32();
    fl.server_ip = rand_word32();
    fl.client_port = rand_port();
    fl.server_port = rand_port();
    // Bases close to the top make the sequence sums wrap.
    if ($urandom_range(0, 3) == 0) fl.acked = 32'hFFFF_FFFF - $urandom_range(0, 5000);
    else fl.acked = rand_word32();
    fl.expected = rand_word32();
    return fl;
  endfunction

  // Offers one flow record; with drain set it first waits until every word is out.
  task automatic send_flow(input tcprst_pkg::flow_t fl, input bit drain);
    int gap;
    if ($urandom_range(0, 29) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 17);
    if (drain || gap > 0) push <= 1'b0;
    if (drain) begin
      do @(posedge clk_i); while (sb.pending() != 0);
    end
    repeat (gap) @(posedge clk_i);
    push <= 1'b1;
    drive_flow <= fl;
    do @(posedge clk_i); while (full);
    sb.add_flow(fl);
  endtask

  initial begin
    frame_word_t got;
    int gap;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 59) == 0) receiver_calm = !receiver_calm;
      gap = receiver_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got = '{frame_word_o, valid_bytes_o, packet_number_o, packet_end_o, last_o};
      sb.check_word(got);
    end
  end

  initial begin
    tcprst_pkg::flow_t directed[DirectedCount];
    sb = new();
    directed[0] = '0;
    directed[1] = '1;
    directed[2] = {48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 32'hC0A8_0001, 32'h0A00_0002,
                   16'd51234, 16'd80, 32'hFFFF_FFFF, 32'h1234_5678};
    // These two records make the third and then the first forged sequence wrap to zero.
    directed[3] = {48'h0000_0000_0001, 48'h8000_0000_0000, 32'h0000_0001, 32'h8000_0000,
                   16'h0000, 16'hFFFF, 32'hFFFF_FA4C, 32'h0000_0000};
    directed[4] = {48'h8000_0000_0000, 48'h0000_0000_0001, 32'h8000_0000, 32'h0000_0001,
                   16'hFFFF, 16'h0000, 32'hFFFF_EEE4, 32'h8000_0000};
    directed[5] = {48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                   16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555};
    directed[6] = {48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                   16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA};
    // Addresses chosen so the IP header sum folds to all ones and the checksum is zero.
    directed[7] = {48'h0, 48'h0, 32'h0000_0000, 32'h0000_BBD0,
                   16'd0, 16'd0, 32'd0, 32'd0};
    directed[8] = {48'hFFFF_FFFF_FFFF, 48'h0, 32'hFFFF_FFFF, 32'h0,
                   16'hFFFF, 16'h0, 32'h0, 32'hFFFF_FFFF};
    directed[9] = {48'h0, 48'hFFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                   16'h0, 16'hFFFF, 32'hFFFF_FFFF, 32'h0};
    directed[10] = {48'h1122_3344_5566, 48'h6655_4433_2211, 32'h7F00_0001, 32'h7F00_0001,
                    16'd443, 16'd443, 32'h0000_1000, 32'hFFFF_F000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DirectedCount; i++) send_flow(directed[i], 1'b0);
    for (int i = 0; i < RandomCount; i++) send_flow(rand_flow(), i == 0 || i == 200);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
